[hdl/vbnc_pkg.sv]
// Shared types, constants and helpers for the voxel boundary neighbor counter.
package vbnc_pkg;

    localparam int MAX_X       = 64;
    localparam int MAX_Y       = 64;
    localparam int MAX_Z       = 1024;
    localparam int ID_BITS     = 32;
    localparam int NEIGH_COUNT = 6;

    // field widths
    localparam int SX_W  = 7;
    localparam int SY_W  = 7;
    localparam int SZ_W  = 11;
    localparam int FID_W = 32;
    localparam int CNT_W = 3;

    // id window: two planes, circular by voxel number
    localparam int PLANE_MAX = MAX_X * MAX_Y;
    localparam int WIN       = 2 * PLANE_MAX;
    localparam int AW        = $clog2(WIN);
    localparam int OFF_W     = AW + 1;

    // window read taps (offsets behind the slot of the next write)
    localparam int NUM_TAPS = 6;
    localparam int TAP_ZM   = 0;  // z - 1
    localparam int TAP_YM   = 1;  // y - 1
    localparam int TAP_XM   = 2;  // x - 1
    localparam int TAP_OWN  = 3;  // the voxel itself
    localparam int TAP_XP   = 4;  // x + 1
    localparam int TAP_YP   = 5;  // y + 1

    // APB register map
    localparam int APB_AW = 4;
    localparam logic [APB_AW-3:0] REG_SIZE_X = 2'd0;
    localparam logic [APB_AW-3:0] REG_SIZE_Y = 2'd1;
    localparam logic [APB_AW-3:0] REG_SIZE_Z = 2'd2;

    typedef logic signed [ID_BITS-1:0] t_id;
    typedef logic [AW-1:0]             t_addr;
    typedef logic [OFF_W-1:0]          t_off;

    typedef struct packed {
        logic [SX_W-1:0] sx;
        logic [SY_W-1:0] sy;
        logic [SZ_W-1:0] sz;
    } t_cfg;

    typedef struct packed {
        logic adv;  // window moves on by one voxel
        logic we;   // a real id is stored
    } t_win_ctl;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             last;
    } t_result;

    function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                   input logic [SZ_W-1:0] hi);
        logic [SZ_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SZ_W'(1);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic id_positive(input t_id v);
        return !v[ID_BITS-1] && (v != '0);
    endfunction

    localparam logic [SX_W-1:0] RST_SX = SX_W'(clamp_size(SZ_W'(64), SZ_W'(MAX_X)));
    localparam logic [SY_W-1:0] RST_SY = SY_W'(clamp_size(SZ_W'(64), SZ_W'(MAX_Y)));
    localparam logic [SZ_W-1:0] RST_SZ = clamp_size(SZ_W'(1024), SZ_W'(MAX_Z));

endpackage

[hdl/vbnc_ram.sv]
// Simple dual-port id RAM with registered, write-first read.
module vbnc_ram import vbnc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_id   i_wdata,
    input  t_addr i_raddr,
    output t_id   o_rdata
);

    t_id mem [WIN];
    t_id r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/vbnc_regs.sv]
// APB size registers with saturation and volume restart strobe.
module vbnc_regs import vbnc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_restart
);

    logic              wr;
    logic [APB_AW-3:0] idx;
    t_cfg              r_cfg;
    t_cfg              n_cfg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[APB_AW-1:2];

    always_comb begin
        n_cfg     = r_cfg;
        o_restart = 1'b0;
        if (wr) begin
            case (idx)
                REG_SIZE_X: begin
                    n_cfg.sx  = SX_W'(clamp_size(SZ_W'(pwdata[SX_W-1:0]), SZ_W'(MAX_X)));
                    o_restart = 1'b1;
                end
                REG_SIZE_Y: begin
                    n_cfg.sy  = SY_W'(clamp_size(SZ_W'(pwdata[SY_W-1:0]), SZ_W'(MAX_Y)));
                    o_restart = 1'b1;
                end
                REG_SIZE_Z: begin
                    n_cfg.sz  = clamp_size(pwdata[SZ_W-1:0], SZ_W'(MAX_Z));
                    o_restart = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sx <= RST_SX;
            r_cfg.sy <= RST_SY;
            r_cfg.sz <= RST_SZ;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (idx)
            REG_SIZE_X: prdata = 32'(r_cfg.sx);
            REG_SIZE_Y: prdata = 32'(r_cfg.sy);
            REG_SIZE_Z: prdata = 32'(r_cfg.sz);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/vbnc_window.sv]
// Two-plane circular id window with six prefetched read taps.
module vbnc_window import vbnc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_win_ctl i_ctl,
    input  t_cfg     i_cfg,
    input  t_id      i_wdata,
    output t_id      o_taps [NUM_TAPS]
);

    t_addr r_ptr;
    t_addr n_ptr;
    t_off  plane;
    t_off  off   [NUM_TAPS];
    t_addr raddr [NUM_TAPS];

    // slot that the next advance writes
    always_comb begin
        n_ptr = r_ptr;
        if (i_ctl.adv) begin
            n_ptr = (r_ptr == AW'(WIN - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // tap addresses follow the upcoming write slot; the banks register the reads
    always_comb begin
        t_off d;
        plane         = OFF_W'(OFF_W'(i_cfg.sx) * OFF_W'(i_cfg.sy));
        off[TAP_ZM]   = plane << 1;
        off[TAP_YM]   = plane + OFF_W'(i_cfg.sx);
        off[TAP_XM]   = plane + OFF_W'(1);
        off[TAP_OWN]  = plane;
        off[TAP_XP]   = plane - OFF_W'(1);
        off[TAP_YP]   = plane - OFF_W'(i_cfg.sx);
        for (int i = 0; i < NUM_TAPS; i++) begin
            d = {1'b0, n_ptr} - off[i];
            if ({1'b0, n_ptr} < off[i]) begin
                d = d + OFF_W'(WIN);
            end
            raddr[i] = d[AW-1:0];
        end
    end

    for (genvar g = 0; g < NUM_TAPS; g++) begin : g_bank
        vbnc_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (i_ctl.we),
            .i_waddr (r_ptr),
            .i_wdata (i_wdata),
            .i_raddr (raddr[g]),
            .o_rdata (o_taps[g])
        );
    end

endmodule

[hdl/vbnc_outq.sv]
// Result output register with one skid entry.
module vbnc_outq import vbnc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    n_out_valid;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_out;
    t_result n_out;
    t_result r_skid;
    t_result n_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into full output stage");

endmodule

[hdl/voxel_boundary_neighbor_count_top.sv]
// Top level of the six-connected boundary voxel neighbor counter.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------
//  config    in         APB psel/penable/pwrite   paddr, pwdata (prdata on read)
//  input     in         i_in_valid / o_in_ready   i_kind, i_feature_id
//  result    out        o_out_valid / i_out_ready o_neighbor_count, o_last_voxel
//
//  One transaction per cycle sustained while o_in_ready is high; each result is
//  registered in the output stage or its skid. The rate is set by six replicated
//  window RAM banks, each serving one prefetched tap read per cycle.
//  Synchronous active-low reset clears counters and flags; the id window has no
//  reset and needs no clearing pass (only ids of the current volume are read).
//  A stalled result parks in a one-entry skid; o_in_ready drops only when it is full.
module voxel_boundary_neighbor_count_top import vbnc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_kind,
    input  logic signed [FID_W-1:0] i_feature_id,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CNT_W-1:0]        o_neighbor_count,
    output logic                    o_last_voxel
);

    t_cfg     cfg;
    logic     restart;
    t_win_ctl win_ctl;
    t_id      taps [NUM_TAPS];
    t_id      cur_id;
    t_result  res;
    t_result  out_data;

    logic in_acc;
    logic is_vox;
    logic is_drain;
    logic emit;

    // receive side: coordinates of the next incoming voxel
    logic [SX_W-1:0] r_rx, n_rx;
    logic [SY_W-1:0] r_ry, n_ry;
    logic [SZ_W-1:0] r_rz, n_rz;
    logic            r_past, n_past;  // first plane complete, results flowing
    logic            r_all,  n_all;   // whole volume received
    // emit side: coordinates of the voxel whose result goes out next
    logic [SX_W-1:0] r_ex, n_ex;
    logic [SY_W-1:0] r_ey, n_ey;
    logic [SZ_W-1:0] r_ez, n_ez;

    logic rx_end, ry_end, rz_end;
    logic ex_end, ey_end, ez_end;

    vbnc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    assign cur_id = i_feature_id[ID_BITS-1:0];

    // Voxels past the volume and drain ticks before the end do nothing.
    assign in_acc   = i_in_valid && o_in_ready;
    assign is_vox   = in_acc && !i_kind && !r_all;
    assign is_drain = in_acc && i_kind && r_all;
    assign emit     = (is_vox && r_past) || is_drain;

    // drain ticks still move the window so tap offsets stay aligned
    assign win_ctl.adv = is_vox || is_drain;
    assign win_ctl.we  = is_vox;

    vbnc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (win_ctl),
        .i_cfg   (cfg),
        .i_wdata (cur_id),
        .o_taps  (taps)
    );

    assign rx_end = (r_rx == cfg.sx - SX_W'(1));
    assign ry_end = (r_ry == cfg.sy - SY_W'(1));
    assign rz_end = (r_rz == cfg.sz - SZ_W'(1));
    assign ex_end = (r_ex == cfg.sx - SX_W'(1));
    assign ey_end = (r_ey == cfg.sy - SY_W'(1));
    assign ez_end = (r_ez == cfg.sz - SZ_W'(1));

    // Neighbor test. The +z neighbor is the voxel arriving right now; on drain
    // ticks the emitted voxel sits in the last plane so that neighbor is out.
    always_comb begin
        t_id                    own;
        t_id                    nb  [NEIGH_COUNT];
        logic [NEIGH_COUNT-1:0] ok;
        logic [CNT_W-1:0]       cnt;
        own   = taps[TAP_OWN];
        nb[0] = taps[TAP_ZM];
        nb[1] = taps[TAP_YM];
        nb[2] = taps[TAP_XM];
        nb[3] = taps[TAP_XP];
        nb[4] = taps[TAP_YP];
        nb[5] = cur_id;
        ok[0] = (r_ez != '0);
        ok[1] = (r_ey != '0);
        ok[2] = (r_ex != '0);
        ok[3] = !ex_end;
        ok[4] = !ey_end;
        ok[5] = !ez_end;
        cnt   = '0;
        for (int i = 0; i < NEIGH_COUNT; i++) begin
            if (ok[i] && id_positive(nb[i]) && (nb[i] != own)) begin
                cnt = cnt + CNT_W'(1);
            end
        end
        res.count = id_positive(own) ? cnt : '0;
        res.last  = ex_end && ey_end && ez_end;
    end

    // raster counters for both sides
    always_comb begin
        n_rx   = r_rx;
        n_ry   = r_ry;
        n_rz   = r_rz;
        n_past = r_past;
        n_all  = r_all;
        n_ex   = r_ex;
        n_ey   = r_ey;
        n_ez   = r_ez;
        if (is_vox) begin
            if (!rx_end) begin
                n_rx = r_rx + SX_W'(1);
            end else begin
                n_rx = '0;
                if (!ry_end) begin
                    n_ry = r_ry + SY_W'(1);
                end else begin
                    n_ry   = '0;
                    n_past = 1'b1;
                    if (!rz_end) begin
                        n_rz = r_rz + SZ_W'(1);
                    end else begin
                        n_rz  = '0;
                        n_all = 1'b1;
                    end
                end
            end
        end
        if (emit) begin
            if (!ex_end) begin
                n_ex = r_ex + SX_W'(1);
            end else begin
                n_ex = '0;
                if (!ey_end) begin
                    n_ey = r_ey + SY_W'(1);
                end else begin
                    n_ey = '0;
                    n_ez = ez_end ? '0 : r_ez + SZ_W'(1);
                end
            end
            // final voxel out: volume done, ready for the next one
            if (res.last) begin
                n_rx   = '0;
                n_ry   = '0;
                n_rz   = '0;
                n_past = 1'b0;
                n_all  = 1'b0;
            end
        end
        if (restart) begin
            n_rx   = '0;
            n_ry   = '0;
            n_rz   = '0;
            n_past = 1'b0;
            n_all  = 1'b0;
            n_ex   = '0;
            n_ey   = '0;
            n_ez   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx   <= '0;
            r_ry   <= '0;
            r_rz   <= '0;
            r_past <= 1'b0;
            r_all  <= 1'b0;
            r_ex   <= '0;
            r_ey   <= '0;
            r_ez   <= '0;
        end else begin
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_rz   <= n_rz;
            r_past <= n_past;
            r_all  <= n_all;
            r_ex   <= n_ex;
            r_ey   <= n_ey;
            r_ez   <= n_ez;
        end
    end

    vbnc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (res),
        .o_space (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_neighbor_count = out_data.count;
    assign o_last_voxel     = out_data.last;

    a_emit_in_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ex < cfg.sx) && (r_ey < cfg.sy) && (r_ez < cfg.sz))
        else $error("emit coordinate outside the volume");

    a_all_implies_past: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all |-> r_past)
        else $error("volume received without first plane complete");

    a_all_rx_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_all |-> ((r_rx == '0) && (r_ry == '0) && (r_rz == '0)))
        else $error("receive coordinates not wrapped after full volume");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && res.last && !restart) |=>
            (!r_all && !r_past && (r_ex == '0) && (r_ey == '0) && (r_ez == '0)))
        else $error("volume state not cleared after final voxel");

endmodule

[verif/voxel_boundary_neighbor_count_top_test.sv]
// Self-checking testbench for the six-connected boundary voxel neighbor counter.
module voxel_boundary_neighbor_count_top_test;
    import vbnc_pkg::*;

    // input item kinds
    localparam logic KIND_VOXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // register index with nothing behind it
    localparam logic [APB_AW-3:0] REG_UNUSED = 2'd3;

    // cycles allowed after the last result before the block counts as idle
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 120;
    localparam int PRINT_LIMIT   = 100;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_AW-1:0]       paddr        = '0;
    logic [31:0]             pwdata       = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic                    i_kind       = KIND_VOXEL;
    logic signed [FID_W-1:0] i_feature_id = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [CNT_W-1:0]        o_neighbor_count;
    logic                    o_last_voxel;

    voxel_boundary_neighbor_count_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_feature_id    (i_feature_id),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_neighbor_count(o_neighbor_count),
        .o_last_voxel    (o_last_voxel)
    );

    // 2-unit clock period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: sizes, stream counters and the two-plane id window
    // ------------------------------------------------------------------
    int unsigned cfg_sx;
    int unsigned cfg_sy;
    int unsigned cfg_sz;
    int unsigned vox_in;    // voxels taken in for the current volume
    int unsigned vox_out;   // voxels whose count has been produced
    t_id         id_win [WIN];

    t_result     pending_counts [$];   // expected results, oldest first
    t_result     head_count;
    int          mismatches    = 0;
    int          useful_items  = 0;    // items that move the stream along
    int          send_idle_pct = 0;
    int          ready_idle_pct = 0;

    function automatic int unsigned saturate_size(input int unsigned v, input int unsigned hi);
        if (v < 1) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Id of voxel idx; the voxel arriving in this transaction is not stored yet.
    function automatic t_id window_id(input int unsigned idx, input bit has_cur,
                                      input int unsigned cur_idx, input t_id cur_id);
        if (has_cur && idx == cur_idx) begin
            return cur_id;
        end
        return id_win[idx % WIN];
    endfunction

    // Count for the next voxel in emission order; advances the emit pointer and
    // wraps both counters once the volume's last voxel is done.
    function automatic t_result boundary_count_of_next(input bit has_cur,
                                                       input int unsigned cur_idx,
                                                       input t_id cur_id);
        int unsigned v;
        int unsigned plane;
        int unsigned total;
        int unsigned px;
        int unsigned py;
        int unsigned pz;
        int unsigned cnt;
        int unsigned nb_idx [NEIGH_COUNT];
        bit          nb_ok  [NEIGH_COUNT];
        t_id         own;
        t_id         nb;
        t_result     res;
        int          i;
        v     = vox_out;
        plane = cfg_sx * cfg_sy;
        total = plane * cfg_sz;
        px    = v % cfg_sx;
        py    = (v / cfg_sx) % cfg_sy;
        pz    = v / plane;
        own   = window_id(v, has_cur, cur_idx, cur_id);
        nb_idx[0] = v - plane;  nb_ok[0] = pz > 0;
        nb_idx[1] = v - cfg_sx; nb_ok[1] = py > 0;
        nb_idx[2] = v - 1;      nb_ok[2] = px > 0;
        nb_idx[3] = v + 1;      nb_ok[3] = px + 1 < cfg_sx;
        nb_idx[4] = v + cfg_sx; nb_ok[4] = py + 1 < cfg_sy;
        nb_idx[5] = v + plane;  nb_ok[5] = pz + 1 < cfg_sz;
        cnt = 0;
        if (own > 0) begin
            for (i = 0; i < NEIGH_COUNT; i++) begin
                if (nb_ok[i]) begin
                    nb = window_id(nb_idx[i], has_cur, cur_idx, cur_id);
                    if (nb > 0 && nb != own) begin
                        cnt++;
                    end
                end
            end
        end
        res.count = cnt[CNT_W-1:0];
        res.last  = (v + 1 == total);
        vox_out = v + 1;
        if (vox_out >= total) begin
            vox_out = 0;
            vox_in  = 0;
        end
        return res;
    endfunction

    function automatic void predict_transaction(input logic kind, input t_id fid);
        int unsigned plane;
        int unsigned total;
        int unsigned r;
        plane = cfg_sx * cfg_sy;
        total = plane * cfg_sz;
        if (kind == KIND_VOXEL) begin
            // voxels past the end of the volume are dropped
            if (vox_in < total) begin
                r      = vox_in;
                vox_in = r + 1;
                if (r >= plane) begin
                    pending_counts.push_back(boundary_count_of_next(1'b1, r, fid));
                end
                id_win[r % WIN] = fid;
            end
        end else if (vox_in >= total && vox_out < total) begin
            // a drain tick only counts once the whole volume is in
            pending_counts.push_back(boundary_count_of_next(1'b0, 0, '0));
        end
    endfunction

    // Register write; any known register also restarts the volume.
    function automatic void apply_register(input logic [APB_AW-3:0] idx,
                                           input logic [31:0] data);
        case (idx)
            REG_SIZE_X: begin
                cfg_sx = saturate_size(data & 32'h7F, MAX_X);
            end
            REG_SIZE_Y: begin
                cfg_sy = saturate_size(data & 32'h7F, MAX_Y);
            end
            REG_SIZE_Z: begin
                cfg_sz = saturate_size(data & 32'h7FF, MAX_Z);
            end
            default: begin
                return;
            end
        endcase
        vox_in  = 0;
        vox_out = 0;
    endfunction

    function automatic logic [31:0] reg_value(input logic [APB_AW-3:0] idx);
        case (idx)
            REG_SIZE_X: return cfg_sx;
            REG_SIZE_Y: return cfg_sy;
            REG_SIZE_Z: return cfg_sz;
            default:    return '0;
        endcase
    endfunction

    function automatic void reset_predictor();
        int i;
        for (i = 0; i < WIN; i++) begin
            id_win[i] = '0;
        end
        vox_in  = 0;
        vox_out = 0;
        cfg_sx  = saturate_size(64, MAX_X);
        cfg_sy  = saturate_size(64, MAX_Y);
        cfg_sz  = saturate_size(1024, MAX_Z);
        pending_counts.delete();
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH @%0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: every edge, take register writes and input transactions
    // into the predictor, then check any result transaction against the
    // oldest expectation. Prediction goes first so a same-edge result
    // would still find its expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                apply_register(paddr[APB_AW-1:2], pwdata);
            end
            if (i_in_valid && o_in_ready) begin
                predict_transaction(i_kind, i_feature_id);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_counts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result count=%0d last=%0b",
                                              o_neighbor_count, o_last_voxel));
                end else begin
                    head_count = pending_counts.pop_front();
                    if (o_neighbor_count != head_count.count) begin
                        report_mismatch($sformatf("neighbor_count got %0d want %0d",
                                                  o_neighbor_count, head_count.count));
                    end
                    if (o_last_voxel != head_count.last) begin
                        report_mismatch($sformatf("last_voxel got %0b want %0b",
                                                  o_last_voxel, head_count.last));
                    end
                end
            end
        end
    end

    // Result side back-pressure; the stall rate follows the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= ready_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input transaction. Valid is left high on return so back-to-back
    // items need no gap; it is dropped by the idle loop or by settle().
    task automatic send_item(input logic kind, input logic [FID_W-1:0] fid);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_feature_id <= fid;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending, wait for every expected result, then let the pipe empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-3:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input logic [APB_AW-3:0] idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got != reg_value(idx)) begin
            report_mismatch($sformatf("register %0d reads %0d want %0d",
                                      idx, got, reg_value(idx)));
        end
    endtask

    task automatic configure(input int unsigned sx, input int unsigned sy,
                             input int unsigned sz);
        settle();
        apb_write(REG_SIZE_X, sx);
        apb_write(REG_SIZE_Y, sy);
        apb_write(REG_SIZE_Z, sz);
    endtask

    // Mostly a handful of small ids so that equal and differing neighbors
    // both show up; now and then zero, negative or any 32-bit value.
    function automatic logic [FID_W-1:0] random_id();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom | 32'h8000_0000;
            2:       return $urandom;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom_range(3, 1);
        endcase
    endfunction

    // A whole volume: all voxels, then one drain tick per pending result.
    // With noise: stray drain ticks mid-stream, a voxel past the end, or the
    // volume cut short and abandoned.
    task automatic send_volume(input int unsigned sx, input int unsigned sy,
                               input int unsigned sz, input bit noisy);
        int unsigned total;
        int unsigned stop;
        int unsigned n;
        total = sx * sy * sz;
        stop  = total;
        if (noisy && $urandom_range(7) == 0) begin
            stop = $urandom_range(total - 1);
        end
        configure(sx, sy, sz);
        for (n = 0; n < stop; n++) begin
            if (noisy && $urandom_range(19) == 0) begin
                send_item(KIND_DRAIN, $urandom);
            end
            send_item(KIND_VOXEL, random_id());
            useful_items++;
        end
        if (stop < total) begin
            return;
        end
        if (noisy && $urandom_range(3) == 0) begin
            send_item(KIND_VOXEL, random_id());
        end
        repeat (sx * sy) begin
            send_item(KIND_DRAIN, $urandom);
            useful_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Size registers saturate at both ends, drop bits above their width,
    // and an unmapped index changes nothing.
    task automatic test_register_saturation();
        settle();
        apb_write(REG_SIZE_X, 32'd0);
        check_register(REG_SIZE_X);
        apb_write(REG_SIZE_X, 32'd127);
        check_register(REG_SIZE_X);
        apb_write(REG_SIZE_X, 32'hFFFF_FF83);
        check_register(REG_SIZE_X);
        apb_write(REG_SIZE_Y, 32'd0);
        check_register(REG_SIZE_Y);
        apb_write(REG_SIZE_Y, 32'd65);
        check_register(REG_SIZE_Y);
        apb_write(REG_SIZE_Z, 32'd0);
        check_register(REG_SIZE_Z);
        apb_write(REG_SIZE_Z, 32'd2047);
        check_register(REG_SIZE_Z);
        apb_write(REG_SIZE_Z, 32'h800);
        check_register(REG_SIZE_Z);
        apb_write(REG_UNUSED, 32'd5);
        check_register(REG_SIZE_X);
        check_register(REG_SIZE_Y);
        check_register(REG_SIZE_Z);
    endtask

    // One-plane volume: nothing comes out while streaming, all of it by drain.
    // Also covers idle and early drain ticks, a voxel past the end, and the
    // id extremes.
    task automatic test_single_plane();
        configure(3, 2, 1);
        send_item(KIND_DRAIN, 32'hFFFF_FFFF);      // nothing pending yet
        send_item(KIND_VOXEL, 32'h7FFF_FFFF);
        send_item(KIND_VOXEL, 32'h8000_0000);
        send_item(KIND_VOXEL, 32'h0000_0000);
        send_item(KIND_DRAIN, 32'h0000_0000);      // volume not complete
        send_item(KIND_VOXEL, 32'h0000_0001);
        send_item(KIND_VOXEL, 32'hFFFF_FFFF);
        send_item(KIND_VOXEL, 32'h0000_0002);
        send_item(KIND_VOXEL, 32'h0000_0003);      // past the end
        repeat (6) send_item(KIND_DRAIN, 32'h5555_AAAA);
        send_item(KIND_DRAIN, 32'hAAAA_5555);      // volume done, nothing left
    endtask

    // Two planes: results for the first plane come out while streaming.
    task automatic test_two_planes();
        configure(2, 1, 2);
        send_item(KIND_VOXEL, 32'd5);
        send_item(KIND_VOXEL, 32'd5);
        send_item(KIND_VOXEL, 32'd6);
        send_item(KIND_VOXEL, 32'd7);
        repeat (2) send_item(KIND_DRAIN, 32'd0);
    endtask

    // Sender holds off until every result is back, then a register write
    // in mid-volume starts the volume over.
    task automatic test_restart_after_pause();
        configure(1, 1, 3);
        send_item(KIND_VOXEL, 32'd4);
        send_item(KIND_VOXEL, 32'd9);
        settle();
        apb_write(REG_SIZE_Z, 32'd3);
        send_item(KIND_VOXEL, 32'd9);
        send_item(KIND_VOXEL, 32'd4);
        send_item(KIND_VOXEL, 32'd4);
        send_item(KIND_DRAIN, 32'd0);
    endtask

    // Widest row, tallest plane, single voxel, and the deepest volume
    // (only its opening planes, then abandoned).
    task automatic test_extreme_sizes();
        send_volume(MAX_X, 1, 1, 1'b0);
        send_volume(1, MAX_Y, 1, 1'b0);
        send_volume(1, 1, 1, 1'b0);
        configure(1, 1, 2047);
        repeat (40) begin
            send_item(KIND_VOXEL, random_id());
        end
    endtask

    // Random volumes, mostly small, sometimes one axis at its maximum.
    // Back-pressure phases: receiver-heavy idling, then sender-heavy, then none.
    task automatic test_random_volumes();
        int start;
        int done;
        int unsigned sx;
        int unsigned sy;
        int unsigned sz;
        start = useful_items;
        done  = 0;
        while (done < RANDOM_ITEMS) begin
            if (done < RANDOM_ITEMS / 3) begin
                send_idle_pct  = 34;
                ready_idle_pct = 72;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct  = 72;
                ready_idle_pct = 34;
            end else begin
                send_idle_pct  = 0;
                ready_idle_pct = 0;
            end
            case ($urandom_range(15))
                0: begin
                    sx = MAX_X;
                    sy = 1;
                    sz = $urandom_range(2, 1);
                end
                1: begin
                    sx = 1;
                    sy = MAX_Y;
                    sz = $urandom_range(2, 1);
                end
                2: begin
                    sx = 1;
                    sy = 1;
                    sz = $urandom_range(40, 20);
                end
                default: begin
                    sx = $urandom_range(5, 1);
                    sy = $urandom_range(5, 1);
                    sz = $urandom_range(5, 1);
                end
            endcase
            send_volume(sx, sy, sz, 1'b1);
            done = useful_items - start;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_predictor();
        send_idle_pct  = 34;
        ready_idle_pct = 72;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_saturation();
        test_single_plane();
        test_two_planes();
        test_restart_after_pause();

        send_idle_pct  = 72;
        ready_idle_pct = 34;
        test_extreme_sizes();

        test_random_volumes();

        settle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/vbnc_pkg.sv
hdl/vbnc_ram.sv
hdl/vbnc_regs.sv
hdl/vbnc_window.sv
hdl/vbnc_outq.sv
hdl/voxel_boundary_neighbor_count_top.sv
verif/voxel_boundary_neighbor_count_top_test.sv
